/* rtl/triangle_face_normal_centroid_macros.svh */
// Assertion macros for the triangle normal block
`ifndef TRIANGLE_FACE_NORMAL_CENTROID_MACROS_SVH
`define TRIANGLE_FACE_NORMAL_CENTROID_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define TFN_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
// next-cycle implication
`define TFN_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define TFN_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TFN_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/tfn_pkg.sv */
package tfn_pkg;
	localparam int CW = 24;

	// reciprocal of three: floor(x/3) == (x*M)>>28 for x below 2^27
	localparam logic [26:0] DIV3_M = 27'd89478486;
	localparam int DIV3_SH = 28;

	typedef logic signed [CW-1:0] coord_t;

	// data carried beside the normal path
	typedef struct packed {
		logic degen;
		logic [2:0] neg;
		logic [2:0][CW-1:0] ctr;
	} side_t;

	// one square root step: radicand, partial remainder and root
	typedef struct packed {
		logic [61:0] rad;
		logic [31:0] rem;
		logic [30:0] root;
		logic [2:0][29:0] mag;
		side_t side;
	} sqd_t;
endpackage

/* rtl/tfn_sqrt_cell.sv */
module tfn_sqrt_cell (
	input logic clk,
	input logic arst_n,
	input logic vld_i,
	input tfn_pkg::sqd_t d_i,
	output logic vld_o,
	output tfn_pkg::sqd_t d_o
);
	import tfn_pkg::*;

	logic [33:0] remx, trial;
	logic ge;
	sqd_t nxt;

	// retire two radicand bits per cell
	always_comb begin
		remx = {d_i.rem, d_i.rad[61:60]};
		trial = {1'b0, d_i.root, 2'b01};
		ge = (remx >= trial);
		nxt = d_i;
		nxt.rad = {d_i.rad[59:0], 2'b00};
		nxt.rem = ge ? 32'(remx - trial) : 32'(remx);
		nxt.root = {d_i.root[29:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else begin
			vld_o <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		d_o <= nxt;
	end
endmodule

/* rtl/tfn_div_cell.sv */
module tfn_div_cell #(
	parameter int QW = 14
) (
	input logic clk,
	input logic arst_n,
	input logic vld_i,
	input logic [2:0][30:0] rem_i,
	input logic [2:0][QW-1:0] num_i,
	input logic [2:0][QW-1:0] quo_i,
	input logic [30:0] len_i,
	input tfn_pkg::side_t side_i,
	output logic vld_o,
	output logic [2:0][30:0] rem_o,
	output logic [2:0][QW-1:0] num_o,
	output logic [2:0][QW-1:0] quo_o,
	output logic [30:0] len_o,
	output tfn_pkg::side_t side_o
);
	import tfn_pkg::*;

	logic [2:0][31:0] remx;
	logic [2:0] ge;
	logic [2:0][30:0] rem_n;
	logic [2:0][QW-1:0] num_n, quo_n;

	// one quotient bit per lane
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			remx[l] = {rem_i[l], num_i[l][QW-1]};
			ge[l] = (remx[l] >= {1'b0, len_i});
			rem_n[l] = ge[l] ? 31'(remx[l] - {1'b0, len_i}) : 31'(remx[l]);
			num_n[l] = {num_i[l][QW-2:0], 1'b0};
			quo_n[l] = {quo_i[l][QW-2:0], ge[l]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else begin
			vld_o <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		rem_o <= rem_n;
		num_o <= num_n;
		quo_o <= quo_n;
		len_o <= len_i;
		side_o <= side_i;
	end
endmodule

/* rtl/triangle_face_normal_centroid.sv */
// channel   signals                          transfer
// --------  -------------------------------  ---------------------------
// command   start, busy, a_*/b_*/c_*          start high while busy low
// result    done, center_*, tip_*, degenerate one cycle with done high
//
// One triangle is taken every cycle; busy stays low.
// The result passes through ten setup stages, 31 square root cells, a
// numerator stage, FRAC_BITS+2 divider cells and the output register.
// Reset clears only the valid bits; the pipeline holds no state between items.
// The result cannot be stalled and is shown for exactly one cycle.
`include "triangle_face_normal_centroid_macros.svh"
module triangle_face_normal_centroid #(
	parameter int FRAC_BITS = 12
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input tfn_pkg::coord_t a_x,
	input tfn_pkg::coord_t a_y,
	input tfn_pkg::coord_t a_z,
	input tfn_pkg::coord_t b_x,
	input tfn_pkg::coord_t b_y,
	input tfn_pkg::coord_t b_z,
	input tfn_pkg::coord_t c_x,
	input tfn_pkg::coord_t c_y,
	input tfn_pkg::coord_t c_z,
	output logic done,
	output tfn_pkg::coord_t center_x,
	output tfn_pkg::coord_t center_y,
	output tfn_pkg::coord_t center_z,
	output tfn_pkg::coord_t tip_x,
	output tfn_pkg::coord_t tip_y,
	output tfn_pkg::coord_t tip_z,
	output logic degenerate
);
	import tfn_pkg::*;

	localparam int QW = FRAC_BITS + 2;
	localparam int NW = FRAC_BITS + 31;
	localparam int UW = FRAC_BITS + 3;
	localparam int LAT = 43 + QW;

	coord_t pa[3], pb[3], pc[3];
	assign pa = '{a_x, a_y, a_z};
	assign pb = '{b_x, b_y, b_z};
	assign pc = '{c_x, c_y, c_z};

	assign busy = 1'b0;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9, vld_s10;
	logic signed [24:0] u_s1[3], v_s1[3];
	logic signed [25:0] sm_s1[3];
	logic signed [49:0] pr_s2[6];
	logic [25:0] pa_s2[3];
	logic [2:0] sn_s2, sn_s3;
	logic signed [50:0] cr_s3[3];
	logic [52:0] dq_s3[3];
	logic [2:0][49:0] mag_s4, mag_s5, mag_s6, mag_s7;
	logic [2:0] neg_s4;
	logic [2:0][CW-1:0] ctr_s4;
	logic [49:0] mx_c, mx_s5;
	side_t side_s5, side_s6, side_s7, side_s8, side_s9, side_s10;
	logic [4:0] any_c, any_s6;
	logic [4:0][3:0] pos_c, pos_s6;
	logic [5:0] p_c, lsh_s7;
	logic [2:0][49:0] shf_c;
	logic [2:0][29:0] norm_s8, norm_s9, norm_s10;
	logic [2:0][59:0] sq_s9;
	logic [61:0] sum_s10;

	// take differences and corner sums
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			u_s1[i] <= 25'(pb[i]) - 25'(pa[i]);
			v_s1[i] <= 25'(pc[i]) - 25'(pa[i]);
			sm_s1[i] <= 26'(pa[i]) + 26'(pb[i]) + 26'(pc[i]);
		end
	end

	// form cross product terms and rounded magnitude of sums
	always_ff @(posedge clk) begin
		pr_s2[0] <= u_s1[1] * v_s1[2];
		pr_s2[1] <= u_s1[2] * v_s1[1];
		pr_s2[2] <= u_s1[2] * v_s1[0];
		pr_s2[3] <= u_s1[0] * v_s1[2];
		pr_s2[4] <= u_s1[0] * v_s1[1];
		pr_s2[5] <= u_s1[1] * v_s1[0];
		for (int i = 0; i < 3; i++) begin
			pa_s2[i] <= (sm_s1[i][25] ? 26'(-sm_s1[i]) : 26'(sm_s1[i])) + 26'd1;
			sn_s2[i] <= sm_s1[i][25];
		end
	end

	// subtract cross terms and scale sums by the reciprocal of three
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			cr_s3[i] <= 51'(pr_s2[2*i]) - 51'(pr_s2[2*i+1]);
			dq_s3[i] <= 53'(pa_s2[i]) * 53'(DIV3_M);
		end
		sn_s3 <= sn_s2;
	end

	// split cross components into sign and magnitude; finish centroid
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			neg_s4[i] <= cr_s3[i][50];
			mag_s4[i] <= cr_s3[i][50] ? 50'(-cr_s3[i]) : 50'(cr_s3[i]);
			ctr_s4[i] <= sn_s3[i] ? 24'd0 - dq_s3[i][DIV3_SH+CW-1:DIV3_SH]
				: dq_s3[i][DIV3_SH+CW-1:DIV3_SH];
		end
	end

	// find largest magnitude
	always_comb begin
		mx_c = mag_s4[0];
		if (mag_s4[1] > mx_c) mx_c = mag_s4[1];
		if (mag_s4[2] > mx_c) mx_c = mag_s4[2];
	end

	always_ff @(posedge clk) begin
		mx_s5 <= mx_c;
		mag_s5 <= mag_s4;
		side_s5.degen <= (mag_s4 == '0);
		side_s5.neg <= neg_s4;
		side_s5.ctr <= ctr_s4;
	end

	// locate leading one in each ten-bit group
	always_comb begin
		for (int g = 0; g < 5; g++) begin
			any_c[g] = |mx_s5[10*g +: 10];
			pos_c[g] = '0;
			for (int b = 0; b < 10; b++) begin
				if (mx_s5[10*g+b]) pos_c[g] = 4'(b);
			end
		end
	end

	always_ff @(posedge clk) begin
		any_s6 <= any_c;
		pos_s6 <= pos_c;
		mag_s6 <= mag_s5;
		side_s6 <= side_s5;
	end

	// pick highest group and derive left-align shift
	always_comb begin
		p_c = '0;
		for (int g = 0; g < 5; g++) begin
			if (any_s6[g]) p_c = 6'(10*g) + 6'(pos_s6[g]);
		end
	end

	always_ff @(posedge clk) begin
		lsh_s7 <= 6'd49 - p_c;
		mag_s7 <= mag_s6;
		side_s7 <= side_s6;
	end

	// align so largest magnitude lies in [2^29, 2^30)
	always_comb begin
		for (int i = 0; i < 3; i++) shf_c[i] = mag_s7[i] << lsh_s7;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) norm_s8[i] <= shf_c[i][49:20];
		side_s8 <= side_s7;
	end

	// square the scaled magnitudes
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) sq_s9[i] <= 60'(norm_s8[i]) * 60'(norm_s8[i]);
		norm_s9 <= norm_s8;
		side_s9 <= side_s8;
	end

	// add the squares
	always_ff @(posedge clk) begin
		sum_s10 <= 62'(sq_s9[0]) + 62'(sq_s9[1]) + 62'(sq_s9[2]);
		norm_s10 <= norm_s9;
		side_s10 <= side_s9;
	end

	// advance valid through setup stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
			vld_s10 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
			vld_s10 <= vld_s9;
		end
	end

	// square root chain
	logic [31:0] sq_vld;
	sqd_t sq_d[32];

	assign sq_vld[0] = vld_s10;
	always_comb begin
		sq_d[0].rad = sum_s10;
		sq_d[0].rem = '0;
		sq_d[0].root = '0;
		sq_d[0].mag = norm_s10;
		sq_d[0].side = side_s10;
	end

	for (genvar k = 0; k < 31; k++) begin : g_sqrt
		tfn_sqrt_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.vld_i(sq_vld[k]),
			.d_i(sq_d[k]),
			.vld_o(sq_vld[k+1]),
			.d_o(sq_d[k+1])
		);
	end

	// build rounded numerators for the divide
	logic vld_s11;
	logic [2:0][30:0] rem_s11;
	logic [2:0][QW-1:0] num_s11;
	logic [30:0] len_s11;
	side_t side_s11;
	logic [2:0][NW-1:0] numr_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			numr_c[i] = (NW'(sq_d[31].mag[i]) << FRAC_BITS) + NW'(sq_d[31].root[30:1]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s11 <= 1'b0;
		end else begin
			vld_s11 <= sq_vld[31];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			rem_s11[i] <= 31'(numr_c[i][NW-1:QW]);
			num_s11[i] <= numr_c[i][QW-1:0];
		end
		len_s11 <= sq_d[31].root;
		side_s11 <= sq_d[31].side;
	end

	// divider chain
	logic [QW:0] dv_vld;
	logic [2:0][30:0] dv_rem[QW+1];
	logic [2:0][QW-1:0] dv_num[QW+1];
	logic [2:0][QW-1:0] dv_quo[QW+1];
	logic [30:0] dv_len[QW+1];
	side_t dv_side[QW+1];

	assign dv_vld[0] = vld_s11;
	assign dv_rem[0] = rem_s11;
	assign dv_num[0] = num_s11;
	assign dv_quo[0] = '0;
	assign dv_len[0] = len_s11;
	assign dv_side[0] = side_s11;

	for (genvar k = 0; k < QW; k++) begin : g_div
		tfn_div_cell #(.QW(QW)) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.vld_i(dv_vld[k]),
			.rem_i(dv_rem[k]),
			.num_i(dv_num[k]),
			.quo_i(dv_quo[k]),
			.len_i(dv_len[k]),
			.side_i(dv_side[k]),
			.vld_o(dv_vld[k+1]),
			.rem_o(dv_rem[k+1]),
			.num_o(dv_num[k+1]),
			.quo_o(dv_quo[k+1]),
			.len_o(dv_len[k+1]),
			.side_o(dv_side[k+1])
		);
	end

	// apply signs (x unit vector if degenerate), add centroid and saturate
	side_t fs;
	logic signed [UW-1:0] unit_c[3];
	logic signed [25:0] tsum_c[3];
	coord_t tip_c[3];

	assign fs = dv_side[QW];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (fs.degen) begin
				unit_c[i] = (i == 0) ? UW'(1) <<< FRAC_BITS : '0;
			end else if (fs.neg[i]) begin
				unit_c[i] = UW'(0) - UW'(dv_quo[QW][i]);
			end else begin
				unit_c[i] = UW'(dv_quo[QW][i]);
			end
			tsum_c[i] = 26'($signed(fs.ctr[i])) + 26'(unit_c[i]);
			if (tsum_c[i] > 26'sd8388607) begin
				tip_c[i] = 24'sh7FFFFF;
			end else if (tsum_c[i] < -26'sd8388608) begin
				tip_c[i] = 24'sh800000;
			end else begin
				tip_c[i] = 24'(tsum_c[i]);
			end
		end
	end

	logic done_q;
	logic degen_q;
	coord_t ctr_q[3], tip_q[3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dv_vld[QW];
		end
	end

	// hold result registers
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			ctr_q[i] <= $signed(fs.ctr[i]);
			tip_q[i] <= tip_c[i];
		end
		degen_q <= fs.degen;
	end

	assign done = done_q;
	assign center_x = ctr_q[0];
	assign center_y = ctr_q[1];
	assign center_z = ctr_q[2];
	assign tip_x = tip_q[0];
	assign tip_y = tip_q[1];
	assign tip_z = tip_q[2];
	assign degenerate = degen_q;

	`TFN_ASSERT_IMP(a_degen_tip, clk, arst_n, done && degenerate,
		tip_y == center_y && tip_z == center_z)
	`TFN_ASSERT_IMP(a_latency, clk, arst_n, done, $past(vld_s1, LAT - 1))
	`TFN_ASSERT_NXT(a_enter, clk, arst_n, start && !busy, vld_s1)
endmodule
